// ===== sv/rbal_pkg.sv =====
// ----------------------------------------------------------------------------
// rbal_pkg
// Shared constants and types for the running box average line block.
// ----------------------------------------------------------------------------
package rbal_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int MAX_LINE   = 4096;

    // ring pointer, line position and used count widths, and the radius limit
    localparam int WPTR_W = $clog2(MAX_WINDOW);
    localparam int POS_W  = $clog2(MAX_LINE) + 1;
    localparam int R_MAX  = (MAX_WINDOW - 1) / 2;

    // field and register widths
    localparam int SAMPLE_W  = 16;
    localparam int CENTER_W  = 12;
    localparam int RADIUS_W  = 5;
    localparam int SHIFT_W   = 4;
    localparam int SKIP_W    = 2;
    localparam int LINELEN_W = 13;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 13;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_LEN = 4'd3;

    // word carried from the accept stage to the sum stage
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                first;
        logic                used;
        logic                produce;
        logic                self_read;
        logic [CENTER_W-1:0] center;
    } t_s1;

endpackage

// ===== sv/rbal_ram.sv =====
// ----------------------------------------------------------------------------
// rbal_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rbal_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/running_box_average_line.sv =====
// ----------------------------------------------------------------------------
// running_box_average_line
// Running box sum along one line with a ring memory of recent samples.
// ----------------------------------------------------------------------------
// Takes one sample per cycle while o_stall is low and gives one result per cycle
// once the window is full, unless i_stall holds the output. In the cycle a sample
// is accepted it issues the read of the leaving sample and, if used, writes the
// ring memory; when the sum stage fires it adds the new sample, forms the result,
// subtracts the leaving sample and loads the output register. The single ring
// memory port pair and the registered sum loop set this rate. Configuration
// writes are taken at any time but are meant to land while the block is idle.
module running_box_average_line
    import rbal_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // sample channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [SAMPLE_W-1:0]  i_sample,
    input  logic                 i_line_start,
    // result channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [SAMPLE_W-1:0]  o_average,
    output logic [CENTER_W-1:0]  o_center,
    // configuration channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    // configuration
    logic [RADIUS_W-1:0]  r_radius;
    logic [SHIFT_W-1:0]   r_out_shift;
    logic [SKIP_W-1:0]    r_skip;
    logic [LINELEN_W-1:0] r_line_len;

    // accept stage state
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [WPTR_W-1:0] r_wp, n_wp;
    logic [POS_W-1:0]  r_cnt, n_cnt;

    // sum stage
    logic              r_s1_valid;
    t_s1               r_s1, n_s1;
    logic [SAMPLE_W-1:0] r_sum, n_sum;

    // output register
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_avg;
    logic [CENTER_W-1:0] r_center;

    logic acc, s1_fire;
    logic [POS_W-1:0]  pos, cnt, rad, span, len, skip_e, skip2, ll_e;
    logic [WPTR_W-1:0] wp, rd_addr;
    logic              used;
    logic [SAMPLE_W-1:0] rd_data, old_s, base, sum_in;

    assign o_cfg_ready = 1'b1;
    assign s1_fire     = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall     = r_s1_valid && !s1_fire;
    assign acc         = i_valid && !o_stall;

    // ---- accept stage: position, pointer and window control ----
    always_comb begin
        pos    = i_line_start ? '0 : r_pos;
        wp     = i_line_start ? '0 : r_wp;
        cnt    = i_line_start ? '0 : r_cnt;
        rad    = (POS_W'(r_radius) > POS_W'(R_MAX)) ? POS_W'(R_MAX) : POS_W'(r_radius);
        span   = rad << 1;
        ll_e   = (POS_W > LINELEN_W) ? POS_W'(r_line_len) : r_line_len[POS_W-1:0];
        len    = (ll_e > POS_W'(MAX_LINE)) ? POS_W'(MAX_LINE) : ll_e;
        skip_e = POS_W'(r_skip);
        skip2  = skip_e << 1;
        used   = (pos >= skip_e) && (len >= skip2) && (pos < len - skip_e);
        rd_addr = wp - span[WPTR_W-1:0];

        n_pos = (pos < POS_W'(MAX_LINE)) ? pos + 1'b1 : pos;
        n_wp  = used ? wp + 1'b1 : wp;
        n_cnt = (used && cnt < POS_W'(MAX_LINE)) ? cnt + 1'b1 : cnt;

        n_s1.sample    = i_sample;
        n_s1.first     = i_line_start;
        n_s1.used      = used;
        n_s1.produce   = used && (cnt >= span);
        n_s1.self_read = (rd_addr == wp);
        n_s1.center    = CENTER_W'(pos - rad);
    end

    rbal_ram #(
        .DEPTH (MAX_WINDOW),
        .WIDTH (SAMPLE_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (acc && used),
        .i_waddr (wp),
        .i_wdata (i_sample),
        .i_re    (acc),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // ---- sum stage: add new sample, form result, drop oldest ----
    always_comb begin
        // the leaving sample is the one written in the same cycle at zero radius
        old_s  = r_s1.self_read ? r_s1.sample : rd_data;
        base   = r_s1.first ? '0 : r_sum;
        sum_in = base + r_s1.sample;
        if (!r_s1.used) begin
            n_sum = base;
        end else if (r_s1.produce) begin
            n_sum = sum_in - old_s;
        end else begin
            n_sum = sum_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius    <= RADIUS_W'(1);
            r_out_shift <= SHIFT_W'(1);
            r_skip      <= SKIP_W'(3);
            r_line_len  <= LINELEN_W'(4096);
            r_pos       <= '0;
            r_wp        <= '0;
            r_cnt       <= '0;
            r_sum       <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_RADIUS:   r_radius    <= i_cfg_data[RADIUS_W-1:0];
                    CFG_SHIFT:    r_out_shift <= i_cfg_data[SHIFT_W-1:0];
                    CFG_SKIP:     r_skip      <= i_cfg_data[SKIP_W-1:0];
                    CFG_LINE_LEN: r_line_len  <= i_cfg_data[LINELEN_W-1:0];
                    default: ;
                endcase
            end
            if (acc) begin
                r_pos <= n_pos;
                r_wp  <= n_wp;
                r_cnt <= n_cnt;
            end
            if (acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_sum <= n_sum;
            end
            if (s1_fire && r_s1.produce) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1 <= n_s1;
        end
        if (s1_fire && r_s1.produce) begin
            r_avg    <= sum_in >> r_out_shift;
            r_center <= r_s1.center;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_average = r_avg;
    assign o_center  = r_center;

    // ---- checks ----
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= POS_W'(MAX_LINE) && r_pos <= POS_W'(MAX_LINE))
        else $error("position or used count beyond line limit");

    a_self_only_zero_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && used && rd_addr == wp) |-> span[WPTR_W-1:0] == '0)
        else $error("ring read collides with write at nonzero span");

    a_produce_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1.produce) |-> r_s1.used)
        else $error("result from an unused sample");

    a_accept_loads_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> r_s1_valid)
        else $error("accepted word lost before sum stage");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_s1.produce) |=> o_valid)
        else $error("produced result not presented");

endmodule
